/* hw/rtl/bscc_pkg.sv */
package bscc_pkg;

   // Frame limits and derived widths
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);

   // Result coordinates are always 10 bits wide (masked when the frame is larger)
   localparam int COORD_W  = 10;

   // Register port
   localparam int CSR_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = CSR_IDX_W'(1);

   // Size registers reset to 1024, limited by the build maximum; stored minus one
   localparam int ROWS_RST_M1 = ((MAX_ROWS < 1024) ? MAX_ROWS : 1024) - 1;
   localparam int COLS_RST_M1 = ((MAX_COLS < 1024) ? MAX_COLS : 1024) - 1;

   // Line buffer word: pixel of column c, and anchor of column c-1, from the row above
   localparam int LINE_W   = 2;
   localparam int LINE_PIX = 1;
   localparam int LINE_ANC = 0;

   // Scan position of one pixel, with the flags the evaluation stage needs
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last_col;
      logic             last_row;
      logic             row_ge1;
      logic             row_ge2;
      logic             col_ge1;
      logic             thin;
   } pos_type;

endpackage

/* hw/rtl/bscc_ram.sv */
module bscc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/bscc_scan.sv */
module bscc_scan import bscc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 accept,
   output logic                 restart,
   output pos_type              pos
);

   logic [ROW_W-1:0] rows_m1_ff, rows_m1_in;
   logic [COL_W-1:0] cols_m1_ff, cols_m1_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             hit_rows;
   logic             hit_cols;

   assign hit_rows = csr_we && (csr_index == CSR_ROWS_IN_USE);
   assign hit_cols = csr_we && (csr_index == CSR_COLS_IN_USE);
   assign restart  = hit_rows || hit_cols;

   // Size registers: zero acts as one, too large acts as the maximum
   always_comb begin
      rows_m1_in = rows_m1_ff;
      cols_m1_in = cols_m1_ff;
      if (hit_rows) begin
         if (csr_wdata == '0) begin
            rows_m1_in = '0;
         end else if (32'(csr_wdata) > MAX_ROWS) begin
            rows_m1_in = ROW_W'(MAX_ROWS - 1);
         end else begin
            rows_m1_in = ROW_W'(csr_wdata - 1'b1);
         end
      end
      if (hit_cols) begin
         if (csr_wdata == '0) begin
            cols_m1_in = '0;
         end else if (32'(csr_wdata) > MAX_COLS) begin
            cols_m1_in = COL_W'(MAX_COLS - 1);
         end else begin
            cols_m1_in = COL_W'(csr_wdata - 1'b1);
         end
      end
   end

   // Current position and its flags
   always_comb begin
      pos.row      = row_ff;
      pos.col      = col_ff;
      pos.last_col = (col_ff == cols_m1_ff);
      pos.last_row = (row_ff == rows_m1_ff);
      pos.row_ge1  = (row_ff != '0);
      pos.row_ge2  = (row_ff > ROW_W'(1));
      pos.col_ge1  = (col_ff != '0);
      pos.thin     = (rows_m1_ff == '0) || (cols_m1_ff == '0);
   end

   // Raster counters advance on each accepted word; a restart clears them
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (pos.last_col) begin
            col_in = '0;
            row_in = pos.last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m1_ff <= ROW_W'(ROWS_RST_M1);
         cols_m1_ff <= COL_W'(COLS_RST_M1);
         row_ff     <= '0;
         col_ff     <= '0;
      end else begin
         rows_m1_ff <= rows_m1_in;
         cols_m1_ff <= cols_m1_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

endmodule

/* hw/rtl/bscc_eval.sv */
module bscc_eval import bscc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic               req_valid,
   input  logic               req_pixel,
   output logic               req_ready,
   output logic               accept,
   input  pos_type            pos,
   input  logic [LINE_W-1:0]  line_rdata,
   output logic               line_we,
   output logic [COL_W-1:0]   line_waddr,
   output logic [LINE_W-1:0]  line_wdata,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_anchor_valid,
   output logic [COORD_W-1:0] rsp_anchor_row,
   output logic [COORD_W-1:0] rsp_anchor_col,
   output logic               rsp_frame_end,
   output logic               rsp_frame_fail
);

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_pixel_ff;
   pos_type            s1_pos_ff;
   logic               s1_fire;
   logic [3:0]         win_ff, win_in;
   logic               fail_ff, fail_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               anchor_valid_ff;
   logic [COORD_W-1:0] anchor_row_ff, anchor_col_ff;
   logic               frame_end_ff, frame_fail_ff;

   logic               pl, pul, al, aul;
   logic               up, aup, anc;
   logic               fail_new;
   logic               frame_end;

   // Handshake: stage one moves on when the output register is free or being taken
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Window bits: left pixel, upper-left pixel, left anchor, upper-left anchor
   assign pl  = win_ff[0];
   assign pul = win_ff[1];
   assign al  = win_ff[2];
   assign aul = win_ff[3];

   // 2x2 evaluation; the row above comes from the line buffer read at accept
   always_comb begin
      up  = s1_pos_ff.row_ge1 && line_rdata[LINE_PIX];
      aup = s1_pos_ff.row_ge2 && s1_pos_ff.col_ge1 && line_rdata[LINE_ANC];
      anc = s1_pos_ff.row_ge1 && s1_pos_ff.col_ge1 && s1_pixel_ff && up && pl && pul;

      fail_new = fail_ff;
      if (s1_pos_ff.thin) begin
         if (s1_pixel_ff) begin
            fail_new = 1'b1;
         end
      end else begin
         // upper-left pixel is last seen here: it must be covered by now
         if (s1_pos_ff.row_ge1 && s1_pos_ff.col_ge1 && pul && !(aul || aup || al || anc)) begin
            fail_new = 1'b1;
         end
         // right edge: pixel above is finished
         if (s1_pos_ff.row_ge1 && s1_pos_ff.last_col && up && !(aup || anc)) begin
            fail_new = 1'b1;
         end
         // bottom row: left pixel is finished
         if (s1_pos_ff.last_row && s1_pos_ff.col_ge1 && pl && !(al || anc)) begin
            fail_new = 1'b1;
         end
         // bottom-right corner pixel
         if (s1_pos_ff.last_row && s1_pos_ff.last_col && s1_pixel_ff && !anc) begin
            fail_new = 1'b1;
         end
      end

      frame_end = s1_pos_ff.last_row && s1_pos_ff.last_col;
   end

   // Write back the line buffer entry of this column
   assign line_we    = s1_fire;
   assign line_waddr = s1_pos_ff.col;
   always_comb begin
      line_wdata           = '0;
      line_wdata[LINE_PIX] = s1_pixel_ff;
      line_wdata[LINE_ANC] = anc;
   end

   // Window and fail flag update
   always_comb begin
      win_in  = win_ff;
      fail_in = fail_ff;
      if (restart) begin
         win_in  = '0;
         fail_in = 1'b0;
      end else if (s1_fire) begin
         win_in  = s1_pos_ff.last_col ? 4'b0000 : {aup, anc, up, s1_pixel_ff};
         fail_in = frame_end ? 1'b0 : fail_new;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
         fail_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
         fail_ff      <= fail_in;
      end
   end

   // Payload: stage one and the output register
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_pos_ff   <= pos;
      end
      if (s1_fire) begin
         anchor_valid_ff <= anc;
         anchor_row_ff   <= anc ? COORD_W'(s1_pos_ff.row - 1'b1) : '0;
         anchor_col_ff   <= anc ? COORD_W'(s1_pos_ff.col - 1'b1) : '0;
         frame_end_ff    <= frame_end;
         frame_fail_ff   <= frame_end && fail_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_anchor_valid = anchor_valid_ff;
   assign rsp_anchor_row   = anchor_row_ff;
   assign rsp_anchor_col   = anchor_col_ff;
   assign rsp_frame_end    = frame_end_ff;
   assign rsp_frame_fail   = frame_fail_ff;

endmodule

/* hw/rtl/binary_square_cover_check_top.sv */
// Binary 2x2 square cover check. Pixels arrive in raster order, one per word, and every
// pixel gives exactly one result word, via stage one and the output register: the anchor
// flag and coordinates of the 2x2 square whose lower-right corner is that pixel, and with
// the frame's last pixel a frame_end flag and frame_fail, set when some set pixel lay in
// no all-ones 2x2 square. The block takes one pixel per cycle while results are taken;
// the rate is set by a line buffer of MAX_COLS entries of two bits (pixel and anchor of
// the row above) with one read and one write port, read when a pixel is taken and written
// back one stage later. The buffer needs no clearing after reset. Writing rows_in_use or
// cols_in_use restarts the frame; write them only while no pixel is in flight.
module binary_square_cover_check_top import bscc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_anchor_valid,
   output logic [COORD_W-1:0]   rsp_anchor_row,
   output logic [COORD_W-1:0]   rsp_anchor_col,
   output logic                 rsp_frame_end,
   output logic                 rsp_frame_fail
);

   logic              accept;
   logic              restart;
   pos_type           pos;
   logic [LINE_W-1:0] line_rdata;
   logic              line_we;
   logic [COL_W-1:0]  line_waddr;
   logic [LINE_W-1:0] line_wdata;

   // Raster position and size registers
   bscc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .restart   (restart),
      .pos       (pos)
   );

   // Line buffer; with one column the same entry is read and written in one cycle,
   // but then no anchor exists and the read data is not used
   bscc_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_COLS)
   ) u_line (
      .clock (clock),
      .we    (line_we),
      .waddr (line_waddr),
      .wdata (line_wdata),
      .re    (accept),
      .raddr (pos.col),
      .rdata (line_rdata)
   );

   // Window evaluation and result register
   bscc_eval u_eval (
      .clock            (clock),
      .reset            (reset),
      .restart          (restart),
      .req_valid        (req_valid),
      .req_pixel        (req_pixel),
      .req_ready        (req_ready),
      .accept           (accept),
      .pos              (pos),
      .line_rdata       (line_rdata),
      .line_we          (line_we),
      .line_waddr       (line_waddr),
      .line_wdata       (line_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_anchor_valid (rsp_anchor_valid),
      .rsp_anchor_row   (rsp_anchor_row),
      .rsp_anchor_col   (rsp_anchor_col),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_fail   (rsp_frame_fail)
   );

endmodule

/* hw/rtl/bscc_checker.sv */
module bscc_checker import bscc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_anchor_valid,
   input logic [COORD_W-1:0] rsp_anchor_row,
   input logic [COORD_W-1:0] rsp_anchor_col,
   input logic               rsp_frame_end,
   input logic               rsp_frame_fail
);

   // Result word held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_anchor_valid)
         && $stable(rsp_anchor_row) && $stable(rsp_anchor_col)
         && $stable(rsp_frame_end) && $stable(rsp_frame_fail))
      else $error("result word changed while stalled");

   // Coordinates are zero when no anchor is reported
   a_coord_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_anchor_valid |-> rsp_anchor_row == '0 && rsp_anchor_col == '0)
      else $error("coordinates set without an anchor");

   // Fail flag only travels with frame end
   a_fail_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_fail |-> rsp_frame_end)
      else $error("frame_fail without frame_end");

   // Nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind binary_square_cover_check_top bscc_checker u_bscc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_anchor_valid (rsp_anchor_valid),
   .rsp_anchor_row   (rsp_anchor_row),
   .rsp_anchor_col   (rsp_anchor_col),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_frame_fail   (rsp_frame_fail)
);
